>>> rtl/core/pvot_pkg.sv
package pvot_pkg;

    // Default sizes
    localparam int VRAM_BANKS_DEF = 2;
    localparam int OAM_BYTES_DEF  = 256;

    // Bytes per bank in one byte lane (even or odd addresses)
    localparam int LANE_BYTES = 4096;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Address map
    localparam logic [15:0] VRAM_LO    = 16'h8000;
    localparam logic [15:0] VRAM_HI    = 16'h9FFF;
    localparam logic [15:0] TILE_LIMIT = 16'h9800;
    localparam logic [15:0] OAM_LO     = 16'hFE00;
    localparam logic [15:0] OAM_HI     = 16'hFEFF;
    localparam logic [15:0] ADDR_SCY   = 16'hFF42;
    localparam logic [15:0] ADDR_SCX   = 16'hFF43;
    localparam logic [15:0] ADDR_LYC   = 16'hFF45;
    localparam logic [15:0] ADDR_BGP   = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0  = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1  = 16'hFF49;
    localparam logic [15:0] ADDR_WY    = 16'hFF4A;
    localparam logic [15:0] ADDR_WX    = 16'hFF4B;
    localparam logic [15:0] ADDR_FF4C  = 16'hFF4C;
    localparam logic [15:0] ADDR_VBK   = 16'hFF4F;

    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam logic [7:0] VBK_READ_SET = 8'hFE;
    localparam logic [7:0] VBK_MASK     = 8'h01;

    typedef struct packed {
        logic        func;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_req;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        handled;
        logic        tile_valid;
        logic        tile_bank;
        logic [8:0]  tile_num;
        logic [2:0]  tile_row;
        logic [15:0] tile_pixels;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_slot;

    function automatic t_slot plain_slot(input logic [15:0] addr);
        t_slot s;
        s.hit = 1'b1;
        unique case (addr)
            ADDR_SCY:  s.idx = 3'd0;
            ADDR_SCX:  s.idx = 3'd1;
            ADDR_LYC:  s.idx = 3'd2;
            ADDR_BGP:  s.idx = 3'd3;
            ADDR_OBP0: s.idx = 3'd4;
            ADDR_OBP1: s.idx = 3'd5;
            ADDR_WY:   s.idx = 3'd6;
            ADDR_WX:   s.idx = 3'd7;
            default: begin
                s.hit = 1'b0;
                s.idx = 3'd0;
            end
        endcase
        return s;
    endfunction

    // Pixel x takes bit 7-x of each plane; low plane weight 1, high plane weight 2.
    function automatic logic [15:0] decode_row(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] pix;
        pix = '0;
        for (int x = 0; x < 8; x++) begin
            pix[2*x]   = lo[7-x];
            pix[2*x+1] = hi[7-x];
        end
        return pix;
    endfunction

endpackage

>>> rtl/core/ppu_vram_oam_tile_decoder_core.sv
// o_out_valid rises when the result is loaded into the output register; an accepted request
// waits in S_WAIT until that register is empty or being drained.
// No new request is taken while one waits in S_WAIT; the VRAM/OAM RAMs have a registered read.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (synchronous, active low) clears the state machine, output valid, color mode,
// bank registers and the eight plain registers; VRAM and OAM are not cleared.
module ppu_vram_oam_tile_decoder_core #(
    parameter int VRAM_BANKS = pvot_pkg::VRAM_BANKS_DEF,
    parameter int OAM_BYTES  = pvot_pkg::OAM_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Configuration: color_mode
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    // Request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pvot_pkg::t_req i_in_req,
    // Result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pvot_pkg::t_rsp o_out_rsp
);
    import pvot_pkg::*;

    t_cmd cmd;

    // Sequence each request: accept, then load the result once the output register frees up
    pvot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Memories, registers, tile row decode and the output register
    pvot_datapath #(
        .VRAM_BANKS (VRAM_BANKS),
        .OAM_BYTES  (OAM_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_rsp       (o_out_rsp)
    );

`ifndef ASSERT_OFF
    // Hold off the next request while one is in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("stalled result overwritten");

    // Tile fields stay zero without a decoded row
    a_tile_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.tile_valid) |->
        (o_out_rsp.tile_pixels == '0 && o_out_rsp.tile_num == '0 &&
         o_out_rsp.tile_row == '0 && o_out_rsp.tile_bank == 1'b0))
        else $error("tile fields set without a tile row");

    // A decoded row comes only from a handled write
    a_tile_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.tile_valid) |->
        (o_out_rsp.handled && o_out_rsp.rdata == OPEN_BUS))
        else $error("tile row on a non-write result");
`endif

endmodule

>>> rtl/core/pvot_ram.sv
module pvot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pvot_ctrl.sv
module pvot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output pvot_pkg::t_cmd o_cmd
);
    import pvot_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Output register can take a result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/pvot_datapath.sv
module pvot_datapath #(
    parameter int VRAM_BANKS = pvot_pkg::VRAM_BANKS_DEF,
    parameter int OAM_BYTES  = pvot_pkg::OAM_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  pvot_pkg::t_req i_req,
    input  pvot_pkg::t_cmd i_cmd,
    output pvot_pkg::t_rsp o_rsp
);
    import pvot_pkg::*;

    localparam int LANE_DEPTH = VRAM_BANKS * LANE_BYTES;
    localparam int LANE_AW    = $clog2(LANE_DEPTH);
    localparam int OAM_AW     = $clog2(OAM_BYTES);

    typedef enum logic [1:0] {
        SRC_VRAM,
        SRC_OAM,
        SRC_REG
    } t_src;

    // Configuration and register file
    logic       r_color_mode;
    logic       r_active_bank;
    logic       r_bank_bit;
    logic [7:0] r_plain [8];

    // Request captured at accept
    logic        r_wr;
    t_src        r_src;
    logic        r_odd;
    logic        r_handled;
    logic        r_tile;
    logic        r_bank;
    logic [8:0]  r_tidx;
    logic [2:0]  r_trow;
    logic [7:0]  r_wdata;
    logic [7:0]  r_rd_byte;
    t_rsp        r_rsp;

    logic        wr, is_vram, is_oam, oam_in, is_ff4c, is_vbk, bank_use, odd;
    t_slot       slot;
    logic [LANE_AW-1:0] lane_addr;
    logic [OAM_AW-1:0]  oam_addr;
    logic        even_we, even_re, odd_we, odd_re, oam_we, oam_re;
    logic [7:0]  even_q, odd_q, oam_q;
    logic [7:0]  rd_byte;
    t_src        src;
    logic [7:0]  lo_plane, hi_plane;
    t_rsp        n_rsp;

    // Address decode of the incoming request
    assign wr       = (i_req.func == FUNC_WRITE);
    assign is_vram  = (i_req.addr >= VRAM_LO) && (i_req.addr <= VRAM_HI);
    assign is_oam   = (i_req.addr >= OAM_LO) && (i_req.addr <= OAM_HI);
    assign oam_in   = ({1'b0, i_req.addr[7:0]} < 9'(OAM_BYTES));
    assign is_ff4c  = (i_req.addr == ADDR_FF4C);
    assign is_vbk   = (i_req.addr == ADDR_VBK);
    assign slot     = plain_slot(i_req.addr);
    assign odd      = i_req.addr[0];
    assign bank_use = (VRAM_BANKS > 1) && r_active_bank;

    assign lane_addr = LANE_AW'({bank_use, i_req.addr[12:1]});
    assign oam_addr  = OAM_AW'(i_req.addr[7:0]);

    // Write one lane; read the partner lane on a write, the addressed lane on a read
    assign even_we = i_cmd.accept && is_vram && wr && !odd;
    assign odd_we  = i_cmd.accept && is_vram && wr && odd;
    assign even_re = i_cmd.accept && is_vram && (wr ? odd : !odd);
    assign odd_re  = i_cmd.accept && is_vram && (wr ? !odd : odd);
    assign oam_we  = i_cmd.accept && is_oam && oam_in && wr;
    assign oam_re  = i_cmd.accept && is_oam && oam_in && !wr;

    always_comb begin
        if (slot.hit) begin
            rd_byte = r_plain[slot.idx];
        end else if (is_vbk) begin
            rd_byte = VBK_READ_SET | {7'b0, r_bank_bit};
        end else begin
            rd_byte = OPEN_BUS;
        end
        if (is_vram) begin
            src = SRC_VRAM;
        end else if (is_oam && oam_in) begin
            src = SRC_OAM;
        end else begin
            src = SRC_REG;
        end
    end

    pvot_ram #(.WIDTH(8), .DEPTH(LANE_DEPTH)) u_vram_even (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (lane_addr),
        .i_wdata (i_req.wdata),
        .i_re    (even_re),
        .i_raddr (lane_addr),
        .o_rdata (even_q)
    );

    pvot_ram #(.WIDTH(8), .DEPTH(LANE_DEPTH)) u_vram_odd (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_waddr (lane_addr),
        .i_wdata (i_req.wdata),
        .i_re    (odd_re),
        .i_raddr (lane_addr),
        .o_rdata (odd_q)
    );

    pvot_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam (
        .i_clk   (i_clk),
        .i_we    (oam_we),
        .i_waddr (oam_addr),
        .i_wdata (i_req.wdata),
        .i_re    (oam_re),
        .i_raddr (oam_addr),
        .o_rdata (oam_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode  <= 1'b0;
            r_active_bank <= 1'b0;
            r_bank_bit    <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_plain[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_color_mode <= i_cfg_wdata;
            end
            if (i_cmd.accept && wr && slot.hit) begin
                r_plain[slot.idx] <= i_req.wdata;
            end
            if (i_cmd.accept && wr && is_vbk) begin
                r_bank_bit <= |(i_req.wdata & VBK_MASK);
                if (r_color_mode) begin
                    r_active_bank <= |(i_req.wdata & VBK_MASK);
                end
            end
        end
    end

    // Request fields for the result cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wr      <= wr;
            r_src     <= src;
            r_odd     <= odd;
            r_handled <= is_vram || is_oam || slot.hit || is_ff4c || is_vbk;
            r_tile    <= wr && is_vram && (i_req.addr < TILE_LIMIT);
            r_bank    <= bank_use;
            r_tidx    <= i_req.addr[12:4];
            r_trow    <= i_req.addr[3:1];
            r_wdata   <= i_req.wdata;
            r_rd_byte <= rd_byte;
        end
        if (i_cmd.load_out) begin
            r_rsp <= n_rsp;
        end
    end

    assign lo_plane = r_odd ? even_q : r_wdata;
    assign hi_plane = r_odd ? r_wdata : odd_q;

    always_comb begin
        n_rsp = '0;
        n_rsp.handled = r_handled;
        if (r_wr) begin
            n_rsp.rdata = OPEN_BUS;
        end else begin
            case (r_src)
                SRC_VRAM: n_rsp.rdata = r_odd ? odd_q : even_q;
                SRC_OAM:  n_rsp.rdata = oam_q;
                default:  n_rsp.rdata = r_rd_byte;
            endcase
        end
        if (r_tile) begin
            n_rsp.tile_valid  = 1'b1;
            n_rsp.tile_bank   = r_bank;
            n_rsp.tile_num    = r_tidx;
            n_rsp.tile_row    = r_trow;
            n_rsp.tile_pixels = decode_row(lo_plane, hi_plane);
        end
    end

    assign o_rsp = r_rsp;

endmodule
